FILE: rtl/idsd_pkg.sv
// package with shared types and constants for the id array stream decoder
`timescale 1ns / 1ps
package idsd_pkg;

  localparam int ID_W = 32;
  localparam int CNT_W = 24;
  localparam int BYTE_W = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ID = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELATIVE_MODE = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_VALUE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 8'd3;

  localparam logic [CNT_W-1:0] CAPACITY_RESET = '1;

  // stream byte fields
  localparam int BIT_CONT = 7;
  localparam int BIT_MORE = 6;
  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h40;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ID_RANGE = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_code_t;

  typedef struct packed {
    logic [ID_W-1:0] id_value;
    logic            array_end;
    err_code_t       error_code;
  } result_t;

  // up to two results written into the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } res_push_t;

endpackage

FILE: rtl/idsd_if.sv
// valid/ready channel interfaces for stream bytes, results and configuration writes
`timescale 1ns / 1ps
interface idsd_byte_if;
  logic                          valid;
  logic                          ready;
  logic [idsd_pkg::BYTE_W-1:0]   stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface idsd_result_if;
  logic                          valid;
  logic                          ready;
  logic [idsd_pkg::ID_W-1:0]     id_value;
  logic                          array_end;
  idsd_pkg::err_code_t           error_code;

  modport source (output valid, output id_value, output array_end, output error_code,
                  input ready);
  modport sink (input valid, input id_value, input array_end, input error_code,
                output ready);
endinterface

interface idsd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [idsd_pkg::CFG_INDEX_W-1:0]  index;
  logic [idsd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/idsd_result_fifo.sv
// small result queue taking up to two results per cycle and giving one per cycle while the reader is ready
`timescale 1ns / 1ps
module idsd_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  idsd_pkg::res_push_t push,
  output logic                room_for_two,
  idsd_result_if.source       result
);
  import idsd_pkg::*;

  result_t mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;
  logic [FIFO_CNT_W-1:0] fill;
  logic                  pop;
  logic [FIFO_PTR_W-1:0] wptr_plus1;

  assign pop = result.valid && result.ready;
  assign wptr_plus1 = wptr + FIFO_PTR_W'(1);
  assign room_for_two = fill <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  // output side reads the head entry
  assign result.valid = fill != '0;
  assign result.id_value = mem[rptr].id_value;
  assign result.array_end = mem[rptr].array_end;
  assign result.error_code = mem[rptr].error_code;

  // storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr_plus1] <= push.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      wptr <= wptr + FIFO_PTR_W'(push.count);
      if (pop) begin
        rptr <= rptr + FIFO_PTR_W'(1);
      end
      fill <= fill + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end
  end

endmodule

FILE: rtl/id_array_stream_decoder_core.sv
// top level of the variable-length id array stream decoder
`timescale 1ns / 1ps
// Decodes one stream byte per clock while the output queue has room. A byte
// enters an input register, where it waits until the queue has room; then a
// single pass of logic (shift, delta add, range and capacity compares) writes
// its results into a four-entry output queue, whose head entry drives the
// result port. A byte that ends a nonzero array gives two results (the id and
// the appended terminator), and the output port drains one result per cycle
// while the reader is ready, so a stream of such bytes is held off by the
// output side; other bytes run at one per cycle while nothing stalls. Input is held
// off while the queue has fewer than two free entries. After an id range or
// array overflow error the block drops every further byte until reset.
// Configuration writes are always taken and should only be made while idle.
module id_array_stream_decoder_core (
  input  logic          clk,
  input  logic          rst,
  idsd_byte_if.sink     stream,
  idsd_result_if.source result,
  idsd_cfg_if.sink      cfg
);
  import idsd_pkg::*;

  // configuration registers
  logic [ID_W-1:0]  max_id;
  logic             relative_mode;
  logic [ID_W-1:0]  marker_value;
  logic [CNT_W-1:0] capacity;

  // input register
  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              stage_fire;
  logic              room_for_two;

  // decoder state
  logic [ID_W-1:0]  accumulator;
  logic [ID_W-1:0]  accumulator_next;
  logic [ID_W-1:0]  previous_id;
  logic [ID_W-1:0]  previous_id_next;
  logic [CNT_W-1:0] emitted_count;
  logic [CNT_W-1:0] emitted_count_next;
  logic             halted;
  logic             halted_next;

  res_push_t push;

  // datapath terms
  logic [ID_W-1:0] x_raw;
  logic [ID_W-1:0] x_rel;
  logic [ID_W-1:0] x_val;
  logic            is_marker;
  logic            too_big;
  logic            room0;
  logic            room1;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_id <= '0;
      relative_mode <= 1'b0;
      marker_value <= '0;
      capacity <= CAPACITY_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MAX_ID:        max_id <= cfg.data;
        CFG_RELATIVE_MODE: relative_mode <= cfg.data[0];
        CFG_MARKER_VALUE:  marker_value <= cfg.data;
        CFG_CAPACITY:      capacity <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register, refilled whenever it empties
  assign stage_fire = stage_valid && room_for_two;
  assign stream.ready = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stream.ready) begin
      stage_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      stage_byte <= stream.stream_byte;
    end
  end

  // value decode and checks
  assign x_raw = {accumulator[ID_W-7:0], stage_byte[5:0]};
  assign x_rel = x_raw - ID_W'(1) + previous_id;
  assign x_val = relative_mode ? x_rel : x_raw;
  assign is_marker = relative_mode && (x_raw == '0) && (stage_byte == MARKER_BYTE);
  assign too_big = (max_id != '0) && (x_val >= max_id);
  assign room0 = emitted_count < capacity;
  assign room1 = (emitted_count + CNT_W'(1)) < capacity;

  // per-byte result generation and state update
  always_comb begin
    accumulator_next = accumulator;
    previous_id_next = previous_id;
    emitted_count_next = emitted_count;
    halted_next = halted;
    push.count = 2'd0;
    push.first = '{id_value: '0, array_end: 1'b0, error_code: ERR_NONE};
    push.second = '{id_value: '0, array_end: 1'b1, error_code: ERR_NONE};

    if (stage_fire && !halted) begin
      if (stage_byte[BIT_CONT]) begin
        // continuation byte: take in seven more bits
        accumulator_next = {accumulator[ID_W-8:0], stage_byte[6:0]};
      end else begin
        accumulator_next = '0;
        push.count = 2'd1;
        if (is_marker) begin
          // prereq marker escape
          previous_id_next = '0;
          if (room0) begin
            push.first.id_value = marker_value;
            emitted_count_next = emitted_count + CNT_W'(1);
          end else begin
            push.first.error_code = ERR_OVERFLOW;
            halted_next = 1'b1;
          end
        end else if (too_big) begin
          push.first.error_code = ERR_ID_RANGE;
          halted_next = 1'b1;
          if (relative_mode) begin
            previous_id_next = x_val;
          end
        end else if (!stage_byte[BIT_MORE]) begin
          // array ends here
          previous_id_next = '0;
          if (!room0) begin
            push.first.error_code = ERR_OVERFLOW;
            halted_next = 1'b1;
          end else if (x_val == '0) begin
            push.first.array_end = 1'b1;
            emitted_count_next = emitted_count + CNT_W'(1);
          end else begin
            // id followed by the appended terminator
            push.count = 2'd2;
            push.first.id_value = x_val;
            if (room1) begin
              emitted_count_next = emitted_count + CNT_W'(2);
            end else begin
              emitted_count_next = emitted_count + CNT_W'(1);
              push.second.array_end = 1'b0;
              push.second.error_code = ERR_OVERFLOW;
              halted_next = 1'b1;
            end
          end
        end else begin
          // array goes on; only delta coding tracks the last id
          if (relative_mode) begin
            previous_id_next = x_val;
          end
          if (room0) begin
            push.first.id_value = x_val;
            emitted_count_next = emitted_count + CNT_W'(1);
          end else begin
            push.first.error_code = ERR_OVERFLOW;
            halted_next = 1'b1;
          end
        end
      end
    end
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      previous_id <= '0;
      emitted_count <= '0;
      halted <= 1'b0;
    end else begin
      accumulator <= accumulator_next;
      previous_id <= previous_id_next;
      emitted_count <= emitted_count_next;
      halted <= halted_next;
    end
  end

  // output queue
  idsd_result_fifo u_result_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (room_for_two),
    .result       (result)
  );

  // once halted, only reset clears it
  assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halted flag cleared without reset");

  // nothing is produced while halted
  assert property (@(posedge clk) disable iff (rst) halted |-> push.count == 2'd0)
    else $error("result produced while halted");

  // an error result always halts the block
  assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0 && push.first.error_code != ERR_NONE) |=> halted)
    else $error("error result without halt");

  // a final byte leaves the accumulator empty
  assert property (@(posedge clk) disable iff (rst)
    (stage_fire && !stage_byte[BIT_CONT]) |=> accumulator == '0)
    else $error("accumulator not cleared after final byte");

endmodule
